// File: hw/rtl/beep_burst_pattern_generator_core_defines.svh
// assertion macros used by the beep burst pattern generator checker
`ifndef BEEP_BURST_PATTERN_GENERATOR_CORE_DEFINES_SVH
`define BEEP_BURST_PATTERN_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BBPG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BBPG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/bbpg_pkg.sv
// types and constants of the beep burst pattern generator
package bbpg_pkg;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [2:0] REG_BEEP_COUNT  = 3'd0;
   localparam logic [2:0] REG_PERIOD_MS   = 3'd1;
   localparam logic [2:0] REG_ON_MS       = 3'd2;
   localparam logic [2:0] REG_OFF_MS      = 3'd3;
   localparam logic [2:0] REG_TUNE_VALUE  = 3'd4;
   localparam logic [2:0] REG_CTRL_VALUE  = 3'd5;
   localparam logic [2:0] REG_TONE_ENABLE = 3'd6;

   // register reset values
   localparam logic [7:0]  RST_BEEP_COUNT  = 8'd0;
   localparam logic [15:0] RST_PERIOD_MS   = 16'd1000;
   localparam logic [15:0] RST_ON_MS       = 16'd100;
   localparam logic [15:0] RST_OFF_MS      = 16'd100;
   localparam logic [15:0] RST_TUNE_VALUE  = 16'd0;
   localparam logic [15:0] RST_CTRL_VALUE  = 16'd0;
   localparam logic        RST_TONE_ENABLE = 1'b1;

   // stream widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   // shared divider geometry
   localparam int DIV_N_W   = 24;
   localparam int DIV_D_W   = 16;
   localparam int DIV_CNT_W = 5;

   // arithmetic constants
   localparam logic [DIV_N_W-1:0] FREQ_BASE = 24'd1000000;
   localparam logic [DIV_N_W-1:0] PCT_FULL_Q = 24'd100;
   localparam logic [6:0]         PCT_FULL = 7'd100;

   // result action codes
   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_TONE   = 2'd1,
      ACT_SILENT = 2'd2
   } action_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_FREQ,
      ST_DUTY,
      ST_DONE
   } state_type;

   // configuration register set
   typedef struct packed {
      logic [7:0]  beep_count;
      logic [15:0] period_ms;
      logic [15:0] on_ms;
      logic [15:0] off_ms;
      logic [15:0] tune_value;
      logic [15:0] ctrl_value;
      logic        tone_enable;
   } cfg_type;

endpackage

// File: hw/rtl/beep_burst_pattern_generator_core.sv
// beep burst pattern generator: timers, sequencer and result register
//
//   channel  direction  contents
//   req      in         now_ms timestamp
//   rsp      out        action, tone_freq_hz, tone_duty_pct, beeps_left
//   csr      in/out     seven configuration registers, byte address 4*index
//
// An item with no tone passes from idle through eval and done back to idle; its
// result is registered when done is left. A tone item also passes through freq
// and duty between eval and done: two 24-step passes of the shared divider
// (frequency, then duty). req_tready is high only in the idle state. A new item
// is taken while an earlier result still waits on rsp.
// Synchronous reset clears the timers, the beep count and the result valid flag,
// and returns the sequencer to idle.
module beep_burst_pattern_generator_core
   import bbpg_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   // input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [31:0] now_ms
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // [1:0] action, [21:2] tone_freq_hz,
                                             // [28:22] tone_duty_pct,
                                             // [36:29] beeps_left, [39:37] zero
);

   localparam int CMP_W = (TIME_BITS > 17) ? TIME_BITS : 17;

   cfg_type cfg;

   state_type state_ff, state_in;

   logic [TIME_BITS-1:0] now_ff;
   logic [TIME_BITS-1:0] period_start_ff;
   logic [TIME_BITS-1:0] burst_start_ff;
   logic [7:0]           remaining_ff;
   action_type           act_ff;
   logic [19:0]          freq_ff;
   logic [6:0]           duty_ff;
   logic                 rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [TIME_BITS-1:0] elapsed_p;
   logic [TIME_BITS-1:0] elapsed_b;
   logic [16:0]          on_off_sum;
   logic                 period_over;
   logic                 in_on;
   logic                 in_off;
   logic                 tone_ok;
   logic                 go_tone;
   logic [DIV_N_W-1:0]   duty_num;

   logic                 div_start;
   logic [DIV_N_W-1:0]   div_dividend;
   logic                 div_done;
   logic [DIV_N_W-1:0]   div_quotient;
   logic                 rsp_load;
   logic                 req_xfer;

   bbpg_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bbpg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cfg.tune_value),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // elapsed times and phase decisions
   assign elapsed_p   = now_ff - period_start_ff;
   assign elapsed_b   = now_ff - burst_start_ff;
   assign on_off_sum  = {1'b0, cfg.on_ms} + {1'b0, cfg.off_ms};
   assign period_over = elapsed_p > TIME_BITS'(cfg.period_ms);
   assign in_on       = CMP_W'(elapsed_b) < CMP_W'(cfg.on_ms);
   assign in_off      = CMP_W'(elapsed_b) < CMP_W'(on_off_sum);
   assign tone_ok     = cfg.tone_enable && (cfg.tune_value != 16'd0);
   assign go_tone     = !period_over && (remaining_ff != 8'd0) && in_on && tone_ok;

   // ctrl * 100 as shifted adds
   assign duty_num = {2'b00, cfg.ctrl_value, 6'd0} + {3'b000, cfg.ctrl_value, 5'd0}
                   + {6'd0, cfg.ctrl_value, 2'b00};

   assign req_xfer = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_EVAL;
         ST_EVAL: state_in = go_tone ? ST_FREQ : ST_DONE;
         ST_FREQ: if (div_done) state_in = ST_DUTY;
         ST_DUTY: if (div_done) state_in = ST_DONE;
         ST_DONE: if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready   = 1'b0;
      div_start    = 1'b0;
      div_dividend = FREQ_BASE;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_EVAL: div_start = go_tone;
         ST_FREQ: begin
            div_start    = div_done;
            div_dividend = duty_num;
         end
         ST_DUTY: ;
         ST_DONE: rsp_load = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // capture the timestamp on transfer
   always_ff @(posedge clock) begin
      if (req_xfer) now_ff <= TIME_BITS'(req_tdata);
   end

   // timers and beep count
   always_ff @(posedge clock) begin
      if (reset) begin
         period_start_ff <= '0;
         burst_start_ff  <= '0;
         remaining_ff    <= '0;
      end else if (state_ff == ST_EVAL) begin
         if (period_over) begin
            remaining_ff    <= cfg.beep_count;
            period_start_ff <= now_ff;
            burst_start_ff  <= now_ff;
         end else if (remaining_ff != 8'd0 && !in_on && !in_off) begin
            remaining_ff   <= remaining_ff - 8'd1;
            burst_start_ff <= now_ff;
         end
      end
   end

   // result fields
   always_ff @(posedge clock) begin
      if (state_ff == ST_EVAL) begin
         freq_ff <= '0;
         duty_ff <= '0;
         if (period_over || remaining_ff == 8'd0) act_ff <= ACT_NONE;
         else if (in_on)  act_ff <= tone_ok ? ACT_TONE : ACT_SILENT;
         else if (in_off) act_ff <= ACT_SILENT;
         else             act_ff <= ACT_NONE;
      end else if (state_ff == ST_FREQ && div_done) begin
         freq_ff <= div_quotient[19:0];
      end else if (state_ff == ST_DUTY && div_done) begin
         duty_ff <= (div_quotient > PCT_FULL_Q) ? PCT_FULL : div_quotient[6:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) rsp_data_ff <= {3'b000, remaining_ff, duty_ff, freq_ff, act_ff};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: hw/rtl/bbpg_regs.sv
// configuration register file behind the csr port
module bbpg_regs
   import bbpg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   // register writes on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.beep_count  <= RST_BEEP_COUNT;
         cfg_ff.period_ms   <= RST_PERIOD_MS;
         cfg_ff.on_ms       <= RST_ON_MS;
         cfg_ff.off_ms      <= RST_OFF_MS;
         cfg_ff.tune_value  <= RST_TUNE_VALUE;
         cfg_ff.ctrl_value  <= RST_CTRL_VALUE;
         cfg_ff.tone_enable <= RST_TONE_ENABLE;
      end else if (wr_en) begin
         case (reg_idx)
            REG_BEEP_COUNT:  cfg_ff.beep_count  <= csr_pwdata[7:0];
            REG_PERIOD_MS:   cfg_ff.period_ms   <= csr_pwdata[15:0];
            REG_ON_MS:       cfg_ff.on_ms       <= csr_pwdata[15:0];
            REG_OFF_MS:      cfg_ff.off_ms      <= csr_pwdata[15:0];
            REG_TUNE_VALUE:  cfg_ff.tune_value  <= csr_pwdata[15:0];
            REG_CTRL_VALUE:  cfg_ff.ctrl_value  <= csr_pwdata[15:0];
            REG_TONE_ENABLE: cfg_ff.tone_enable <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_BEEP_COUNT:  csr_prdata = {24'd0, cfg_ff.beep_count};
         REG_PERIOD_MS:   csr_prdata = {16'd0, cfg_ff.period_ms};
         REG_ON_MS:       csr_prdata = {16'd0, cfg_ff.on_ms};
         REG_OFF_MS:      csr_prdata = {16'd0, cfg_ff.off_ms};
         REG_TUNE_VALUE:  csr_prdata = {16'd0, cfg_ff.tune_value};
         REG_CTRL_VALUE:  csr_prdata = {16'd0, cfg_ff.ctrl_value};
         REG_TONE_ENABLE: csr_prdata = {31'd0, cfg_ff.tone_enable};
         default:         csr_prdata = '0;
      endcase
   end

endmodule

// File: hw/rtl/bbpg_divider.sv
// shared restoring divider, one quotient bit per cycle
module bbpg_divider
   import bbpg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] dividend,
   input  logic [DIV_D_W-1:0] divisor,
   output logic               done,
   output logic [DIV_N_W-1:0] quotient
);

   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_D_W+1:0]   trial;
   logic                 last_step;

   // trial subtract of the shifted remainder
   assign trial     = {1'b0, rem_ff, quo_ff[DIV_N_W-1]} - {2'b00, dvs_ff};
   assign last_step = (cnt_ff == DIV_CNT_W'(DIV_N_W - 1));

   always_comb begin
      if (!trial[DIV_D_W+1]) begin
         rem_in = trial[DIV_D_W-1:0];
         quo_in = {quo_ff[DIV_N_W-2:0], 1'b1};
      end else begin
         rem_in = {rem_ff[DIV_D_W-2:0], quo_ff[DIV_N_W-1]};
         quo_in = {quo_ff[DIV_N_W-2:0], 1'b0};
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + DIV_CNT_W'(1);
         if (last_step) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hw/rtl/bbpg_checker.sv
// port-level checks of the beep burst pattern generator
`include "beep_burst_pattern_generator_core_defines.svh"

module bbpg_checker
   import bbpg_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result holds
   `BBPG_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp changed while stalled")

   // block is busy in the cycle after an input transfer
   `BBPG_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready, "req_tready high after transfer")

   // frequency and duty only with tone on
   `BBPG_ASSERT_NOW(a_quiet_fields, rsp_tvalid && rsp_tdata[1:0] != ACT_TONE, rsp_tdata[28:2] == 27'd0, "tone fields set without tone")

   // duty saturates at full scale
   `BBPG_ASSERT_NOW(a_duty_range, rsp_tvalid, rsp_tdata[28:22] <= PCT_FULL, "duty above full scale")

endmodule

bind beep_burst_pattern_generator_core bbpg_checker u_checker (.*);
